FILE: design/dd_odo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Differential-drive odometry package
// Shared command bundle, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dd_odo_pkg;

  // Number of quotient bits produced by the heading divider.
  localparam int unsigned DIV_BITS = 31;
  // Largest number of CORDIC steps the arctangent table supports.
  localparam int unsigned ATAN_ENTRIES = 24;
  // Width of the shared step counter (covers both loops).
  localparam int unsigned IDX_W = 5;

  // CORDIC gain 0.607253 in Q4.30, held in the 34-bit rotation registers.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  // 1/(2*pi) scaled by 2^32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Commands from the sequencer to the datapath, at most one phase per cycle.
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             scale;
    logic             norm;
    logic             div;
    logic             head;
    logic             rot;
    logic             fix;
    logic             mulx;
    logic             muly;
    logic             addy;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Arctangent of 2^-i in units of 2^-32 turn, truncated.
  function automatic logic [29:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933405;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335086;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41721;
      5'd15:   r = 30'd20860;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2607;
      5'd19:   r = 30'd1303;
      5'd20:   r = 30'd651;
      5'd21:   r = 30'd325;
      5'd22:   r = 30'd162;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/diff_drive_odometry_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Differential-drive odometry step
// One Euler integration step of a two-wheel robot pose per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries the two wheel speeds (Q7.8), a time step
// (Q0.16 s) and a restart flag that first reloads the pose from the start
// registers. The heading advances by (right - left) * dt / wheel_base, then
// x and y move by the mean speed times dt along the cosine and sine of the
// new heading. The sequencer steps through the prepare, scale and normalise
// phases, then the heading divider produces one quotient bit per cycle for
// 31 quotient bits; after the heading update the CORDIC rotates one step per
// cycle, followed by the fix, multiply and update phases before the result
// is posted. One transaction is in flight at a time; the result sits in an
// output register, so a new transaction is accepted while the previous
// result still waits to be taken. Configuration writes (index 0 wheel base,
// 1 start x, 2 start y, 3 start heading) take effect at once and should only
// be made while the block is idle.
module diff_drive_odometry_step #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] left_speed_i,
  input  wire logic signed [15:0] right_speed_i,
  input  wire logic [15:0]        time_step_i,
  input  wire logic               restart_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic [15:0]             heading_out_o
);

  dd_odo_pkg::cmd_t cmd;

  // The sequencer owns the handshakes and the loop counters.
  dd_odo_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, pose and all arithmetic.
  dd_odo_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .left_speed_i (left_speed_i),
    .right_speed_i(right_speed_i),
    .time_step_i  (time_step_i),
    .restart_i    (restart_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .heading_out_o(heading_out_o)
  );

endmodule
`default_nettype wire

FILE: design/dd_odo_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry sequencer
// One-hot state machine that steps the datapath through one odometry update.
// ----------------------------------------------------------------------------
module dd_odo_ctrl #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dd_odo_pkg::cmd_t     cmd_o
);

  localparam int unsigned ROT_STEPS = (CORDIC_ITERATIONS > dd_odo_pkg::ATAN_ENTRIES) ?
                                      dd_odo_pkg::ATAN_ENTRIES : CORDIC_ITERATIONS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PREP  = 12'b0000_0000_0010,
    S_SCALE = 12'b0000_0000_0100,
    S_NORM  = 12'b0000_0000_1000,
    S_DIV   = 12'b0000_0001_0000,
    S_HEAD  = 12'b0000_0010_0000,
    S_ROT   = 12'b0000_0100_0000,
    S_FIX   = 12'b0000_1000_0000,
    S_MULX  = 12'b0001_0000_0000,
    S_MULY  = 12'b0010_0000_0000,
    S_ADDY  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [dd_odo_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_NORM;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        idx_d      = dd_odo_pkg::IDX_W'(dd_odo_pkg::DIV_BITS - 1);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (idx_q == '0) begin
          state_d = S_HEAD;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_HEAD: begin
        cmd_o.head = 1'b1;
        idx_d      = '0;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (idx_q == dd_odo_pkg::IDX_W'(ROT_STEPS - 1)) begin
          state_d = S_FIX;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_MULX;
      end
      S_MULX: begin
        cmd_o.mulx = 1'b1;
        state_d    = S_MULY;
      end
      S_MULY: begin
        cmd_o.muly = 1'b1;
        state_d    = S_ADDY;
      end
      S_ADDY: begin
        cmd_o.addy = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // Wait for the output register to be free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: design/dd_odo_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration registers, pose state, divider, CORDIC and move multiplier.
// ----------------------------------------------------------------------------
module dd_odo_dpath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dd_odo_pkg::cmd_t   cmd_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic signed [15:0] left_speed_i,
  input  wire logic signed [15:0] right_speed_i,
  input  wire logic [15:0]        time_step_i,
  input  wire logic               restart_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic [15:0]             heading_out_o
);

  localparam logic [1:0] REG_WHEEL_BASE    = 2'd0;
  localparam logic [1:0] REG_START_X       = 2'd1;
  localparam logic [1:0] REG_START_Y       = 2'd2;
  localparam logic [1:0] REG_START_HEADING = 2'd3;

  // Configuration and pose.
  logic [15:0] wheel_base_q, start_h_q, pose_h_q;
  logic [31:0] start_x_q, start_y_q, pose_x_q, pose_y_q;

  // Item operands.
  logic signed [15:0] left_q, right_q;
  logic [15:0]        dt_q;

  // Working registers.
  logic [31:0]        num_mag_q;
  logic               num_neg_q;
  logic [32:0]        p_mag_q;
  logic               p_neg_q;
  logic [61:0]        mag_q;
  logic [30:0]        n_q;
  logic [15:0]        rem_q, quot_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic [31:0]        c_mag_q, s_mag_q;
  logic               c_neg_q, s_neg_q;
  logic [64:0]        prod_q;
  logic               prod_neg_q;
  logic [31:0]        out_x_q, out_y_q;
  logic [15:0]        out_h_q;

  // Operand preparation.
  logic signed [16:0] diff, sum;
  logic [15:0]        diff_mag;
  logic [16:0]        sum_mag;
  assign diff     = 17'(right_q) - 17'(left_q);
  assign sum      = 17'(right_q) + 17'(left_q);
  assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
  assign sum_mag  = sum[16] ? 17'(-sum) : 17'(sum);

  // Rounding offset for the heading division: half the divisor times 2^32.
  logic [15:0] wb_eff;
  logic [62:0] norm_sum;
  assign wb_eff   = (wheel_base_q == '0) ? 16'd1 : wheel_base_q;
  assign norm_sum = 63'(mag_q) + {16'd0, wb_eff, 31'd0};

  // Restoring divider, one quotient bit per cycle.
  logic [16:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, n_q[cmd_i.idx]};
  assign q_bit  = rem_sh >= {1'b0, wb_eff};

  // Heading update and quadrant fold for the CORDIC.
  logic [15:0] heading_new, dh, h_fold;
  logic        flip;
  assign dh          = num_neg_q ? 16'(-quot_q) : quot_q;
  assign heading_new = pose_h_q + dh;
  assign flip        = heading_new[15] ^ heading_new[14];
  assign h_fold      = {heading_new[15] ^ flip, heading_new[14:0]};

  // CORDIC rotation step.
  logic signed [33:0] x_sh, y_sh, atan_ext;
  assign x_sh     = x_q >>> cmd_i.idx;
  assign y_sh     = y_q >>> cmd_i.idx;
  assign atan_ext = {4'd0, dd_odo_pkg::atan_turn(cmd_i.idx)};

  // Rounded move, shared by both axes.
  logic [63:0] rnd;
  logic [31:0] delta;
  assign rnd   = prod_q[63:0] + 64'(1) * (64'd1 << 38);
  assign delta = prod_neg_q ? 32'(-{7'd0, rnd[63:39]}) : {7'd0, rnd[63:39]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_base_q <= 16'd256;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_h_q    <= '0;
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      pose_h_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WHEEL_BASE:    wheel_base_q <= cfg_data_i[15:0];
          REG_START_X:       start_x_q    <= cfg_data_i;
          REG_START_Y:       start_y_q    <= cfg_data_i;
          REG_START_HEADING: start_h_q    <= cfg_data_i[15:0];
          default:           wheel_base_q <= wheel_base_q;
        endcase
      end
      if (cmd_i.load && restart_i) begin
        pose_x_q <= start_x_q;
        pose_y_q <= start_y_q;
        pose_h_q <= start_h_q;
      end
      if (cmd_i.head) begin
        pose_h_q <= heading_new;
      end
      if (cmd_i.muly) begin
        pose_x_q <= pose_x_q + delta;
      end
      if (cmd_i.addy) begin
        pose_y_q <= pose_y_q + delta;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= left_speed_i;
      right_q <= right_speed_i;
      dt_q    <= time_step_i;
    end
    if (cmd_i.prep) begin
      num_mag_q <= 32'(diff_mag) * 32'(dt_q);
      num_neg_q <= diff[16];
      p_mag_q   <= 33'(sum_mag) * 33'(dt_q);
      p_neg_q   <= sum[16];
    end
    if (cmd_i.scale) begin
      mag_q <= 62'(num_mag_q) * 62'(dd_odo_pkg::INV_TWO_PI);
    end
    if (cmd_i.norm) begin
      n_q    <= norm_sum[62:32];
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.div) begin
      rem_q  <= q_bit ? 16'(rem_sh - {1'b0, wb_eff}) : rem_sh[15:0];
      quot_q <= {quot_q[14:0], q_bit};
    end
    if (cmd_i.head) begin
      x_q    <= dd_odo_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= 34'(signed'({h_fold, 16'd0}));
      flip_q <= flip;
    end
    if (cmd_i.rot) begin
      if (!z_q[33]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_ext;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_ext;
      end
    end
    if (cmd_i.fix) begin
      c_mag_q <= x_q[33] ? 32'(-x_q) : x_q[31:0];
      s_mag_q <= y_q[33] ? 32'(-y_q) : y_q[31:0];
      c_neg_q <= x_q[33] ^ flip_q;
      s_neg_q <= y_q[33] ^ flip_q;
    end
    if (cmd_i.mulx) begin
      prod_q     <= 65'(p_mag_q) * 65'(c_mag_q);
      prod_neg_q <= p_neg_q ^ c_neg_q;
    end
    if (cmd_i.muly) begin
      prod_q     <= 65'(p_mag_q) * 65'(s_mag_q);
      prod_neg_q <= p_neg_q ^ s_neg_q;
    end
    if (cmd_i.out_load) begin
      out_x_q <= pose_x_q;
      out_y_q <= pose_y_q;
      out_h_q <= pose_h_q;
    end
  end

  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;
  assign heading_out_o = out_h_q;

endmodule
`default_nettype wire

FILE: design/dd_odo_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry port checker
// Checks handshake behavior seen at the ports of the odometry step block.
// ----------------------------------------------------------------------------
module dd_odo_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] pos_x_o,
  input wire logic [15:0] heading_out_o
);

  // The block is busy right after it accepts a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was in flight");

  // A result is posted exactly when the sequencer returns to idle.
  a_post_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result posted while still busy");

  // A stalled result stays valid with its x position and heading unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pos_x_o) && $stable(heading_out_o))
    else $error("stalled result changed");

endmodule

bind diff_drive_odometry_step dd_odo_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pos_x_o      (pos_x_o),
  .heading_out_o(heading_out_o)
);
`default_nettype wire

FILE: bench/tb_diff_drive_odometry_step.sv
// ----------------------------------------------------------------------------
// Odometry step regression bench
// Drives wheel-speed transactions through the odometry block, predicts each
// pose update with a bit-accurate model and compares every result field.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_step;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = 40 + STEPS;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned NUM_RANDOM = 850;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_WHEEL_BASE = 2'd0,
    REG_START_X = 2'd1,
    REG_START_Y = 2'd2,
    REG_START_HEADING = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        dt;
    logic               restart;
  } step_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
  } pose_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [15:0] left_speed, right_speed;
  logic [15:0] time_step;
  logic restart;
  logic out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] heading_out;

  diff_drive_odometry_step #(.CORDIC_ITERATIONS(STEPS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .left_speed_i(left_speed), .right_speed_i(right_speed),
    .time_step_i(time_step), .restart_i(restart),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .heading_out_o(heading_out)
  );

  // The bench keeps its own copy of the registers and the pose.
  logic [15:0] mdl_wheel_base;
  logic [31:0] mdl_start_x, mdl_start_y;
  logic [15:0] mdl_start_heading;
  pose_t mdl_pose;

  step_t pending_steps[$];
  pose_t expected_poses[$];

  int unsigned sender_idle_pct, receiver_stall_pct;
  bit hold_off;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Arctangent of 2^-i in 2^-32 turn units, truncated.
  localparam longint ATAN_TBL[24] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81};

  // Rounds |p*c| / 2^39 to nearest, ties away from zero, and wraps to 32 bits.
  function automatic logic [31:0] rounded_move(longint p, longint c);
    logic [63:0] mp, mc, q;
    logic [31:0] d;
    mp = (p < 0) ? -p : p;
    mc = (c < 0) ? -c : c;
    q = (mp * mc + (64'd1 << 38)) >> 39;
    d = q[31:0];
    return ((p < 0) != (c < 0)) ? -d : d;
  endfunction

  // Advances the bench pose by one step and returns the expected result.
  function automatic pose_t odometry_update(step_t s);
    longint l, r, diff, num, x, y, z, xs, ys, p;
    logic [63:0] mag, den, q, wb;
    logic [31:0] a;
    logic [15:0] dh;
    bit flip;
    if (s.restart) begin
      mdl_pose.x = mdl_start_x;
      mdl_pose.y = mdl_start_y;
      mdl_pose.heading = mdl_start_heading;
    end
    l = s.left;
    r = s.right;
    // A wheel base of zero counts as the smallest nonzero value.
    wb = (mdl_wheel_base == 0) ? 64'd1 : 64'(mdl_wheel_base);
    diff = r - l;
    num = diff * longint'(s.dt);
    mag = 64'((num < 0) ? -num : num) * 64'd683565276;
    den = wb << 32;
    q = (mag + (den >> 1)) / den;
    dh = q[15:0];
    if (num < 0) dh = -dh;
    mdl_pose.heading = mdl_pose.heading + dh;

    // Rotation-mode CORDIC; the left half-plane is folded by half a turn.
    a = {mdl_pose.heading, 16'h0000};
    flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) a = a + 32'h8000_0000;
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    p = (l + r) * longint'(s.dt);
    mdl_pose.x = mdl_pose.x + rounded_move(p, x);
    mdl_pose.y = mdl_pose.y + rounded_move(p, y);
    return mdl_pose;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: offers the oldest pending step, with random gaps between steps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      left_speed <= '0;
      right_speed <= '0;
      time_step <= '0;
      restart <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_poses.push_back(odometry_update(pending_steps.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (pending_steps.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          left_speed <= pending_steps[0].left;
          right_speed <= pending_steps[0].right;
          time_step <= pending_steps[0].dt;
          restart <= pending_steps[0].restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expected pose.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result x=%h y=%h heading=%h", pos_x, pos_y, heading_out);
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (e.x !== pos_x || e.y !== pos_y || e.heading !== heading_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                       e.x, e.y, e.heading, pos_x, pos_y, heading_out);
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("diff_drive_odometry_step regression: fail");
        $finish;
      end
    end
  end

  function automatic step_t random_step();
    step_t s;
    s.left = 16'($urandom);
    s.right = 16'($urandom);
    case ($urandom_range(3))
      0: s.dt = 16'($urandom);
      1: s.dt = 16'($urandom_range(2048));
      2: begin
        // Near-straight driving with small speed differences.
        s.right = s.left + $signed(16'($urandom_range(64))) - 16'sd32;
        s.dt = 16'($urandom);
      end
      default: s.dt = (($urandom_range(7)) == 0) ? 16'd0 : 16'hFFFF;
    endcase
    s.restart = ($urandom_range(31) == 0);
    return s;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WHEEL_BASE: mdl_wheel_base = value[15:0];
      REG_START_X: mdl_start_x = value;
      REG_START_Y: mdl_start_y = value;
      default: mdl_start_heading = value[15:0];
    endcase
  endtask

  // Waits until every expected pose has arrived and the block has gone quiet.
  task automatic drain();
    wait (pending_steps.size() == 0 && !in_valid && expected_poses.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic push(logic signed [15:0] l, logic signed [15:0] r, logic [15:0] dt,
                      logic rs);
    step_t s;
    s.left = l;
    s.right = r;
    s.dt = dt;
    s.restart = rs;
    pending_steps.push_back(s);
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_steps.push_back(random_step());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WHEEL_BASE;
    cfg_data = '0;
    mismatches = 0;
    hold_off = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    mdl_wheel_base = 16'd256;
    mdl_start_x = '0;
    mdl_start_y = '0;
    mdl_start_heading = '0;
    mdl_pose = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed steps at reset settings: extremes, zero time step, restart.
    push(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0);
    push(-16'sh8000, -16'sh8000, 16'hFFFF, 1'b0);
    push(-16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
    push(16'sh7FFF, -16'sh8000, 16'hFFFF, 1'b0);
    push(16'sh0100, 16'sh0200, 16'd0, 1'b0);
    push(16'sh0100, 16'sh0100, 16'd1, 1'b1);
    push(16'sh0000, 16'sh0000, 16'h8000, 1'b0);
    push(16'sh0080, 16'sh0480, 16'h4000, 1'b0);
    for (int q = 0; q < 8; q++) push(-16'sh0200, 16'sh0200, 16'h4000 + 16'(q) * 16'h0800, 1'b0);
    drain();

    // Zero wheel base is treated as the smallest one; start pose at extremes.
    write_reg(REG_WHEEL_BASE, 32'd0);
    write_reg(REG_START_X, 32'h7FFF_FFFF);
    write_reg(REG_START_Y, 32'h8000_0000);
    write_reg(REG_START_HEADING, 32'h0000_FFFF);
    push(16'sh0001, 16'sh0002, 16'h0100, 1'b1);
    push(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0);
    push(16'sh1234, -16'sh4321, 16'hFFFF, 1'b1);
    run_phase(150, 0, 0);

    write_reg(REG_WHEEL_BASE, 32'h0000_FFFF);
    write_reg(REG_START_X, 32'h8000_0000);
    write_reg(REG_START_Y, 32'h7FFF_FFFF);
    write_reg(REG_START_HEADING, 32'h0000_8000);
    push(16'sh0000, 16'sh0000, 16'h0000, 1'b1);
    run_phase(200, 45, 0);

    write_reg(REG_WHEEL_BASE, 32'd1);
    write_reg(REG_START_X, $urandom);
    write_reg(REG_START_Y, $urandom);
    write_reg(REG_START_HEADING, $urandom);
    run_phase(200, 0, 45);

    // The receiver holds off for a long stretch while the sender keeps offering.
    write_reg(REG_WHEEL_BASE, 32'd256 + $urandom_range(4096));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) pending_steps.push_back(random_step());
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    run_phase(100, 20, 20);

    write_reg(REG_WHEEL_BASE, $urandom_range(1, 65535));
    run_phase(180, 0, 0);

    if (mismatches == 0) begin
      $display("diff_drive_odometry_step regression: pass");
    end else begin
      $display("diff_drive_odometry_step regression: fail");
    end
    $finish;
  end
endmodule

FILE: diff_drive_odometry_step.f
design/dd_odo_pkg.sv
design/dd_odo_ctrl.sv
design/dd_odo_dpath.sv
design/diff_drive_odometry_step.sv
design/dd_odo_chk.sv
bench/tb_diff_drive_odometry_step.sv
